// File: hw/rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants of the sorted insert priority queue
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ELEMENT  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DUMP   = 1'b1
    } t_action;

    typedef struct packed {
        logic latch;
        logic ins_go;
        logic dump_go;
    } t_cmd;

    typedef struct packed {
        t_action in_action;
        logic    out_free;
        logic    dump_last;
    } t_sts;

endpackage

// File: hw/rtl/sipq_ctrl.sv
// ----------------------------------------------------------------------------
// sipq_ctrl
// Request sequencing: accept, insert step, dump walk
// ----------------------------------------------------------------------------
module sipq_ctrl
    import sipq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = (i_sts.in_action == ACT_DUMP) ? S_DUMP : S_INS;
                end
            end
            S_INS: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_go = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_go = 1'b1;
                    if (i_sts.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/sipq_dpath.sv
// ----------------------------------------------------------------------------
// sipq_dpath
// Sorted slot table with parallel compare-and-shift, dump index, output register
// ----------------------------------------------------------------------------
module sipq_dpath
    import sipq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]    o_m_tuser,
    output logic                   o_m_tlast
);

    logic signed [VALUE_W-1:0] r_value [CAPACITY];
    logic signed [PRIO_W-1:0]  r_prio  [CAPACITY];
    logic signed [VALUE_W-1:0] n_value [CAPACITY];
    logic signed [PRIO_W-1:0]  n_prio  [CAPACITY];
    logic [CAPACITY-1:0]       w_lt;

    logic signed [VALUE_W-1:0] r_in_value;
    logic signed [PRIO_W-1:0]  r_in_prio;
    logic [COUNT_W-1:0]        r_count;
    logic [IDX_W-1:0]          r_idx;

    logic                      r_ov;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_out_value;
    logic signed [PRIO_W-1:0]  r_out_prio;
    logic [OCC_W-1:0]          r_occ;
    logic                      r_last;

    logic w_full;
    logic w_empty;
    logic w_idx_last;
    logic w_out_free;

    assign w_full     = (r_count == COUNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_idx_last = ((COUNT_W'(r_idx) + COUNT_W'(1)) == r_count);
    assign w_out_free = !r_ov || i_m_tready;

    assign o_sts.in_action = t_action'(i_s_tuser);
    assign o_sts.out_free  = w_out_free;
    assign o_sts.dump_last = w_empty || w_idx_last;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i]    = (COUNT_W'(i) < r_count) && (r_in_prio < r_prio[i]);
            n_value[i] = r_value[i];
            n_prio[i]  = r_prio[i];
        end
        if (i_cmd.ins_go && !w_full) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (i > 0 && w_lt[(i > 0) ? i - 1 : 0]) begin
                    n_value[i] = r_value[(i > 0) ? i - 1 : 0];
                    n_prio[i]  = r_prio[(i > 0) ? i - 1 : 0];
                end else if (COUNT_W'(i) == r_count || w_lt[i]) begin
                    n_value[i] = r_in_value;
                    n_prio[i]  = r_in_prio;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_value[i] <= n_value[i];
            r_prio[i]  <= n_prio[i];
        end
        if (i_cmd.latch) begin
            r_in_value <= i_s_tdata[VALUE_W-1:0];
            r_in_prio  <= i_s_tdata[VALUE_W+PRIO_W-1:VALUE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_idx <= '0;
            end else if (i_cmd.dump_go) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.ins_go && !w_full) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.ins_go || i_cmd.dump_go) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_go) begin
            r_status    <= w_full ? ST_FULL : ST_INSERTED;
            r_out_value <= '0;
            r_out_prio  <= '0;
            r_occ       <= w_full ? OCC_W'(r_count) : OCC_W'(r_count + COUNT_W'(1));
            r_last      <= 1'b1;
        end else if (i_cmd.dump_go) begin
            r_status    <= w_empty ? ST_EMPTY : ST_ELEMENT;
            r_out_value <= w_empty ? '0 : r_value[r_idx];
            r_out_prio  <= w_empty ? '0 : r_prio[r_idx];
            r_occ       <= OCC_W'(r_count);
            r_last      <= w_empty || w_idx_last;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {{(OUT_TDATA_W - VALUE_W - PRIO_W - OCC_W){1'b0}},
                         r_occ, r_out_prio, r_out_value};

endmodule

// File: hw/rtl/sorted_insert_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// Priority table of up to 16 (data, priority) entries kept in ascending order
// ----------------------------------------------------------------------------
// An insert request is first accepted, then every slot compares its priority
// with the new one and shifts up in parallel; it gives one result (inserted,
// or full when all 16 slots hold entries). A dump request gives one element
// per cycle while the output does not stall, out of the single output
// register, with tlast on the final one; an empty table gives one empty
// result. A stalled output with a result waiting holds the next step back.
// Equal priorities keep arrival order. A result may wait in the output
// register while the next request is accepted. There is no clearing pass
// after reset.
module sorted_insert_priority_queue_unit
    import sipq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // value, prio
    input  logic                   s_tuser,   // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_value, out_prio, occupancy
    output logic [STATUS_W-1:0]    m_tuser,   // status
    output logic                   m_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    sipq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sipq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker
// Port-level checks of the priority table, bound to the top level
// ----------------------------------------------------------------------------
module sipq_checker
    import sipq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser,
    input logic                   m_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != ST_ELEMENT |-> m_tlast)
        else $error("single result without last");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != ST_ELEMENT |-> m_tdata[VALUE_W+PRIO_W-1:0] == '0)
        else $error("payload not zero");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ST_FULL
            |-> m_tdata[VALUE_W+PRIO_W+OCC_W-1:VALUE_W+PRIO_W] == OCC_W'(CAPACITY))
        else $error("full with wrong occupancy");

endmodule

bind sorted_insert_priority_queue_unit sipq_checker u_sipq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
